/* hw/rtl/rmr_pkg.sv */
// ----------------------------------------------------------------------------
// rmr_pkg: shared types and constants
// Word layouts, sequencer states and control/status bundles for the
// rational multiply and reduce unit.
// ----------------------------------------------------------------------------
package rmr_pkg;

  localparam int OPERAND_W = 16;
  localparam int PROD_W    = 2 * OPERAND_W;
  localparam int ALU_W     = PROD_W + 1;
  localparam int CNT_W     = $clog2(PROD_W);
  localparam int RES_W     = 32;

  typedef struct packed {
    logic signed [OPERAND_W-1:0] num_a;
    logic signed [OPERAND_W-1:0] den_a;
    logic signed [OPERAND_W-1:0] num_b;
    logic signed [OPERAND_W-1:0] den_b;
  } rmr_in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] num_out;
    logic signed [RES_W-1:0] den_out;
  } rmr_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_D,
    S_ABS,
    S_GCD,
    S_DIV_N,
    S_DIV_D,
    S_DONE
  } rmr_state_e;

  typedef struct packed {
    logic load;
    logic mul_d;
    logic abs_ld;
    logic gcd;
    logic div;
    logic div_d;
    logic done;
  } rmr_ctrl_t;

  typedef struct packed {
    logic gcd_done;
    logic g_zero;
    logic div_last;
  } rmr_stat_t;

endpackage

/* hw/rtl/rmr_alu.sv */
// ----------------------------------------------------------------------------
// rmr_alu: shared subtract and compare unit
// Unsigned subtraction with borrow, used by the gcd steps and by the
// restoring divider.
// ----------------------------------------------------------------------------
module rmr_alu
  import rmr_pkg::*;
(
  input  logic [ALU_W-1:0] x_i,
  input  logic [ALU_W-1:0] y_i,
  output logic [ALU_W-1:0] diff_o,
  output logic             borrow_o
);

  assign {borrow_o, diff_o} = {1'b0, x_i} - {1'b0, y_i};

endmodule

/* hw/rtl/rmr_ctrl.sv */
// ----------------------------------------------------------------------------
// rmr_ctrl: sequencer
// Steps one word through multiply, magnitude, gcd and the two divisions.
// ----------------------------------------------------------------------------
module rmr_ctrl
  import rmr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  rmr_stat_t stat_i,
  output rmr_ctrl_t ctrl_o,
  output logic      busy
);

  rmr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_MUL_D;
      end
      S_MUL_D: state_d = S_ABS;
      S_ABS:   state_d = S_GCD;
      S_GCD: begin
        if (stat_i.gcd_done) state_d = stat_i.g_zero ? S_DONE : S_DIV_N;
      end
      S_DIV_N: begin
        if (stat_i.div_last) state_d = S_DIV_D;
      end
      S_DIV_D: begin
        if (stat_i.div_last) state_d = S_DONE;
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy   = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy        = 1'b0;
        ctrl_o.load = start;
      end
      S_MUL_D: ctrl_o.mul_d  = 1'b1;
      S_ABS:   ctrl_o.abs_ld = 1'b1;
      S_GCD:   ctrl_o.gcd    = 1'b1;
      S_DIV_N: ctrl_o.div    = 1'b1;
      S_DIV_D: begin
        ctrl_o.div   = 1'b1;
        ctrl_o.div_d = 1'b1;
      end
      S_DONE:  ctrl_o.done = 1'b1;
      default: busy = 1'b0;
    endcase
  end

endmodule

/* hw/rtl/rmr_dpath.sv */
// ----------------------------------------------------------------------------
// rmr_dpath: datapath
// Shared multiplier, binary gcd and restoring divider registers around one
// subtract unit; forms the signed reduced fraction.
// ----------------------------------------------------------------------------
module rmr_dpath
  import rmr_pkg::*;
(
  input  logic      clk_i,
  input  rmr_in_t   in_i,
  input  rmr_ctrl_t ctrl_i,
  output rmr_stat_t stat_o,
  output rmr_out_t  res_o
);

  logic signed [OPERAND_W-1:0] den_a_q, den_b_q;
  logic signed [OPERAND_W-1:0] mul_x, mul_y;
  logic signed [PROD_W-1:0]    prod;
  logic signed [PROD_W-1:0]    p_q, q_q;
  logic                        neg_p_q, neg_q_q;
  logic [PROD_W-1:0]           a_q, b_q, np_q, nq_q, g_q, rem_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [ALU_W-1:0]            alu_x, alu_y, alu_diff;
  logic                        alu_borrow;
  logic                        a_zero, b_zero;
  logic [PROD_W-1:0]           cur;
  logic                        qbit;
  logic signed [PROD_W-1:0]    num_v, den_v;

  assign mul_x = ctrl_i.mul_d ? den_a_q : in_i.num_a;
  assign mul_y = ctrl_i.mul_d ? den_b_q : in_i.num_b;
  assign prod  = PROD_W'(mul_x) * PROD_W'(mul_y);

  assign a_zero = (a_q == '0);
  assign b_zero = (b_q == '0);
  assign cur    = ctrl_i.div_d ? nq_q : np_q;

  always_comb begin
    if (ctrl_i.div) begin
      alu_x = {rem_q, cur[PROD_W-1]};
      alu_y = {1'b0, g_q};
    end else begin
      alu_x = {1'b0, a_q};
      alu_y = {1'b0, b_q};
    end
  end

  rmr_alu u_alu (
    .x_i      (alu_x),
    .y_i      (alu_y),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow)
  );

  assign qbit = ~alu_borrow;

  assign stat_o.gcd_done = a_zero | b_zero;
  assign stat_o.g_zero   = a_zero & b_zero;
  assign stat_o.div_last = (cnt_q == CNT_W'(PROD_W - 1));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      den_a_q <= in_i.den_a;
      den_b_q <= in_i.den_b;
      p_q     <= prod;
    end
    if (ctrl_i.mul_d) begin
      q_q <= prod;
    end
    if (ctrl_i.abs_ld) begin
      neg_p_q <= p_q[PROD_W-1];
      neg_q_q <= q_q[PROD_W-1];
      a_q     <= p_q[PROD_W-1] ? -p_q : p_q;
      np_q    <= p_q[PROD_W-1] ? -p_q : p_q;
      b_q     <= q_q[PROD_W-1] ? -q_q : q_q;
      nq_q    <= q_q[PROD_W-1] ? -q_q : q_q;
      rem_q   <= '0;
      cnt_q   <= '0;
    end
    if (ctrl_i.gcd) begin
      if (a_zero) begin
        g_q <= b_q;
      end else if (b_zero) begin
        g_q <= a_q;
      end else if (!a_q[0] && !b_q[0]) begin
        a_q  <= a_q >> 1;
        b_q  <= b_q >> 1;
        np_q <= np_q >> 1;
        nq_q <= nq_q >> 1;
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (alu_borrow) begin
        a_q <= b_q;
        b_q <= a_q;
      end else begin
        a_q <= alu_diff[PROD_W-1:0];
      end
    end
    if (ctrl_i.div) begin
      if (stat_o.div_last) begin
        rem_q <= '0;
        cnt_q <= '0;
      end else begin
        rem_q <= qbit ? alu_diff[PROD_W-1:0] : alu_x[PROD_W-1:0];
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (ctrl_i.div_d) begin
        nq_q <= {nq_q[PROD_W-2:0], qbit};
      end else begin
        np_q <= {np_q[PROD_W-2:0], qbit};
      end
    end
  end

  assign num_v = neg_p_q ? -$signed(np_q) : $signed(np_q);
  assign den_v = neg_q_q ? -$signed(nq_q) : $signed(nq_q);

  assign res_o.num_out = RES_W'(num_v);
  assign res_o.den_out = RES_W'(den_v);

`ifndef SYNTH
  a_div_nonzero: assert property (@(posedge clk_i) ctrl_i.div |-> g_q != '0)
    else $error("division started with a zero divisor");
  a_rem_below: assert property (@(posedge clk_i) ctrl_i.div |-> rem_q < g_q)
    else $error("division remainder reached the divisor");
  a_div_one_hot: assert property (@(posedge clk_i)
    $onehot0({ctrl_i.load, ctrl_i.mul_d, ctrl_i.abs_ld, ctrl_i.gcd, ctrl_i.div, ctrl_i.done}))
    else $error("datapath received overlapping steps");
`endif

endmodule

/* hw/rtl/rational_multiply_reduce_unit.sv */
// ----------------------------------------------------------------------------
// rational_multiply_reduce_unit: fraction multiply with gcd reduction
// Multiplies two signed fractions and divides both products by their
// non-negative greatest common divisor; a 0/0 product passes unreduced.
//
// Usage:
//   Input word: drive in_i and raise start; the word is taken at a rising
//   edge with start high and busy low. busy stays high until the result
//   is formed.
//   Result word: res_o is valid for exactly one cycle while res_valid_o is
//   high; the receiver takes it at the end of that cycle and cannot stall.
//   Sequence: after the accepting edge the unit forms the denominator
//   product, then the magnitudes, then the gcd steps (a shift, swap or
//   subtract each, plus a final step that sees the end), then the restoring
//   division of the numerator and then the denominator by the gcd, and
//   registers the result, which raises the strobe. A zero product runs the
//   same steps; the 0/0 case skips the divisions.
//   One word is in flight at a time; start may rise again in the cycle the
//   result is shown.
//   Reset: rst_ni low returns the sequencer to idle and drops res_valid_o;
//   any word in progress is lost.
// ----------------------------------------------------------------------------
module rational_multiply_reduce_unit
  import rmr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  rmr_in_t  in_i,
  output logic     busy,
  output logic     res_valid_o,
  output rmr_out_t res_o
);

  rmr_ctrl_t ctrl;
  rmr_stat_t stat;
  rmr_out_t  res_d, res_q;
  logic      res_valid_q;

  rmr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy)
  );

  rmr_dpath u_dpath (
    .clk_i  (clk_i),
    .in_i   (in_i),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ctrl.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.done) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTH
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held longer than one cycle");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result shown while sequencer still busy");
`endif

endmodule
